>>> design/lc2u8_pkg.sv
// ----------------------------------------------------------------------------
// lc2u8_pkg
// shared types, constants and the windows-1251 table for bytes 0x80 to 0xBF
// ----------------------------------------------------------------------------
`default_nettype none

package lc2u8_pkg;

   localparam logic CHARSET_LATIN1  = 1'b0;
   localparam logic CHARSET_CP1251  = 1'b1;

   localparam logic [15:0] CYRILLIC_OFFSET = 16'h0350;
   localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;

   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   typedef struct packed {
      logic [1:0]      len;
      logic [2:0][7:0] bytes;
   } entry_type;

   function automatic logic [15:0] cp1251_high(input logic [5:0] idx);
      logic [15:0] cp;
      unique case (idx)
         6'd0:  cp = 16'h0402;  6'd1:  cp = 16'h0403;  6'd2:  cp = 16'h201A;
         6'd3:  cp = 16'h0453;  6'd4:  cp = 16'h201E;  6'd5:  cp = 16'h2026;
         6'd6:  cp = 16'h2020;  6'd7:  cp = 16'h2021;  6'd8:  cp = 16'h20AC;
         6'd9:  cp = 16'h2030;  6'd10: cp = 16'h0409;  6'd11: cp = 16'h2039;
         6'd12: cp = 16'h040A;  6'd13: cp = 16'h040C;  6'd14: cp = 16'h040B;
         6'd15: cp = 16'h040F;  6'd16: cp = 16'h0452;  6'd17: cp = 16'h2018;
         6'd18: cp = 16'h2019;  6'd19: cp = 16'h201C;  6'd20: cp = 16'h201D;
         6'd21: cp = 16'h2022;  6'd22: cp = 16'h2013;  6'd23: cp = 16'h2014;
         6'd24: cp = 16'hFFFD;  6'd25: cp = 16'h2122;  6'd26: cp = 16'h0459;
         6'd27: cp = 16'h203A;  6'd28: cp = 16'h045A;  6'd29: cp = 16'h045C;
         6'd30: cp = 16'h045B;  6'd31: cp = 16'h045F;  6'd32: cp = 16'h00A0;
         6'd33: cp = 16'h040E;  6'd34: cp = 16'h045E;  6'd35: cp = 16'h0408;
         6'd36: cp = 16'h00A4;  6'd37: cp = 16'h0490;  6'd38: cp = 16'h00A6;
         6'd39: cp = 16'h00A7;  6'd40: cp = 16'h0401;  6'd41: cp = 16'h00A9;
         6'd42: cp = 16'h0404;  6'd43: cp = 16'h00AB;  6'd44: cp = 16'h00AC;
         6'd45: cp = 16'h00AD;  6'd46: cp = 16'h00AE;  6'd47: cp = 16'h0407;
         6'd48: cp = 16'h00B0;  6'd49: cp = 16'h00B1;  6'd50: cp = 16'h0406;
         6'd51: cp = 16'h0456;  6'd52: cp = 16'h0491;  6'd53: cp = 16'h00B5;
         6'd54: cp = 16'h00B6;  6'd55: cp = 16'h00B7;  6'd56: cp = 16'h0451;
         6'd57: cp = 16'h2116;  6'd58: cp = 16'h0454;  6'd59: cp = 16'h00BB;
         6'd60: cp = 16'h0458;  6'd61: cp = 16'h0405;  6'd62: cp = 16'h0455;
         6'd63: cp = 16'h0457;
         default: cp = 16'hFFFD;
      endcase
      return cp;
   endfunction

endpackage

`default_nettype wire

>>> design/legacy_charset_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// legacy_charset_to_utf8_encoder
// single-byte charset (latin-1 or windows-1251) to utf-8 byte stream
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while busy is low; busy rises only when
// the DEPTH-entry character queue is full. The output sends one utf-8 byte
// per cycle, so a character of n bytes (1 to 3) holds the output for all n
// bytes and sustained throughput, set by the output byte rate, is one item
// per cycle for ascii. The first byte of a character passes from the queue
// to the character register and the output byte register, and may wait behind
// earlier characters. A zero byte is taken and yields nothing. Results cannot
// be held off: each byte is valid for the single cycle rsp_strobe is high.
// ----------------------------------------------------------------------------
`default_nettype none

module legacy_charset_to_utf8_encoder #(
   parameter int DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_char
);
   import lc2u8_pkg::*;

   entry_type push_entry;
   entry_type pop_entry;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;

   lc2u8_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .req_in_byte      (req_in_byte),
      .queue_full       (queue_full),
      .busy             (busy),
      .push             (push),
      .push_entry       (push_entry)
   );

   lc2u8_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   lc2u8_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_char (rsp_last_of_char)
   );

endmodule

`default_nettype wire

>>> design/lc2u8_front.sv
// ----------------------------------------------------------------------------
// lc2u8_front
// holds the charset register, maps each byte to a code point and packs its
// utf-8 bytes into one queue entry
// ----------------------------------------------------------------------------
`default_nettype none

module lc2u8_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_write_data,
   input  wire logic                  start,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  queue_full,
   output logic                       busy,
   output logic                       push,
   output lc2u8_pkg::entry_type       push_entry
);
   import lc2u8_pkg::*;

   logic        charset_ff;
   logic        charset_in;
   logic [15:0] cp;

   assign charset_in = csr_write_enable ? csr_write_data : charset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         charset_ff <= CHARSET_LATIN1;
      end else begin
         charset_ff <= charset_in;
      end
   end

   assign busy = queue_full;
   assign push = start && !busy && (req_in_byte != 8'h00);

   always_comb begin
      if (charset_ff == CHARSET_LATIN1 || !req_in_byte[7]) begin
         cp = {8'h00, req_in_byte};
      end else if (req_in_byte[6]) begin
         cp = CYRILLIC_OFFSET + {8'h00, req_in_byte};
      end else begin
         cp = cp1251_high(req_in_byte[5:0]);
      end
   end

   always_comb begin
      push_entry = '0;
      if (cp < ONE_BYTE_LIMIT) begin
         push_entry.len      = LEN_ONE;
         push_entry.bytes[0] = cp[7:0];
      end else if (cp < TWO_BYTE_LIMIT) begin
         push_entry.len      = LEN_TWO;
         push_entry.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
         push_entry.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      end else begin
         push_entry.len      = LEN_THREE;
         push_entry.bytes[0] = LEAD_THREE | {4'h0, cp[15:12]};
         push_entry.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         push_entry.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      end
   end

endmodule

`default_nettype wire

>>> design/lc2u8_queue.sv
// ----------------------------------------------------------------------------
// lc2u8_queue
// small fifo of encoded characters between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lc2u8_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire lc2u8_pkg::entry_type  push_entry,
   input  wire logic                  pop,
   output lc2u8_pkg::entry_type       pop_entry,
   output logic                       full,
   output logic                       empty
);
   import lc2u8_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full      = count_ff == CW'(DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("push into full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> design/lc2u8_back.sv
// ----------------------------------------------------------------------------
// lc2u8_back
// takes encoded characters from the queue and sends one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lc2u8_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  queue_empty,
   input  wire lc2u8_pkg::entry_type  pop_entry,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_char
);
   import lc2u8_pkg::*;

   entry_type   cur_ff, cur_in;
   logic        active_ff, active_in;
   logic [1:0]  idx_ff, idx_in;
   logic        strobe_ff;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff;
   logic        is_last;

   assign is_last = active_ff && (idx_ff == cur_ff.len - 2'd1);
   assign pop     = !queue_empty && (!active_ff || is_last);

   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      if (pop) begin
         cur_in    = pop_entry;
         active_in = 1'b1;
         idx_in    = '0;
      end else if (is_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    byte_in = cur_ff.bytes[0];
         2'd1:    byte_in = cur_ff.bytes[1];
         default: byte_in = cur_ff.bytes[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         strobe_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      byte_ff <= byte_in;
      last_ff <= is_last;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_of_char = last_ff;

`ifndef SYNTH
   a_char_continues: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !last_ff |=> strobe_ff)
      else $error("character cut short");
   a_last_not_lead: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && last_ff |-> byte_ff[7:6] != 2'b11)
      else $error("final byte is a lead byte");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff < cur_ff.len)
      else $error("byte index past character length");
`endif

endmodule

`default_nettype wire
